[rtl/core/suls_pkg.sv]
// suls_pkg: shared types, codes and constants of the sorted unique list store
// no dependencies; imported by every module of the block but suls_ram

package suls_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned LIMIT_W       = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef struct packed {
    op_e                        op;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   entry_count;
  } out_item_t;

  // index counter operations
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_CLR  = 3'd1,
    IDX_INC  = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_TOP  = 3'd4
  } idx_op_e;

  // ram write selection
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_UP   = 2'd1,
    WR_DOWN = 2'd2,
    WR_PUT  = 2'd3
  } wr_mode_e;

  typedef struct packed {
    logic      capture;
    idx_op_e   idx_op;
    logic      pos_save;
    logic      pos_next;
    logic      rd_next;
    wr_mode_e  wr_mode;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      st_load;
    status_e   st_code;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic empty;
    logic hit;
    logic above;
    logic last;
    logic at_pos;
    logic del_tail;
  } dp_status_t;

endpackage

[rtl/core/suls_ram.sv]
// suls_ram: generic single write port, single read port ram with registered read
// no dependencies

module suls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/suls_datapath.sv]
// suls_datapath: entry ram, index and count registers, comparators, result register
// depends on suls_pkg and suls_ram

module suls_datapath
  import suls_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output out_item_t           out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic [LIMIT_W-1:0]         limit_q;
  op_e                        op_q;
  logic signed [VALUE_W-1:0]  value_q;
  status_e                    st_q;
  out_item_t                  out_q;

  logic [CW-1:0]              idx_nx, idx_nx2;
  logic [AW-1:0]              raddr, waddr;
  logic [VALUE_W-1:0]         wdata;
  logic                       we;
  logic signed [VALUE_W-1:0]  rdata;

  assign idx_nx  = idx_q + CW'(1);
  assign idx_nx2 = idx_q + CW'(2);

  always_comb begin
    idx_d = idx_q;
    case (cmd_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = idx_nx;
      IDX_DEC: idx_d = idx_q - CW'(1);
      IDX_TOP: idx_d = count_q - CW'(1);
      default: idx_d = idx_q;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_save) begin
      pos_d = cmd_i.pos_next ? idx_nx : idx_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    if (cmd_i.capture) begin
      op_q    <= in_data_i.op;
      value_q <= in_data_i.value;
    end
    if (cmd_i.st_load) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.out_load) begin
      out_q.status      <= st_q;
      out_q.entry_count <= COUNT_W'(count_q);
    end
  end

  assign raddr = cmd_i.rd_next ? idx_nx[AW-1:0] : idx_q[AW-1:0];

  always_comb begin
    we    = 1'b1;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    case (cmd_i.wr_mode)
      WR_UP:   waddr = idx_nx[AW-1:0];
      WR_DOWN: waddr = idx_q[AW-1:0];
      WR_PUT: begin
        waddr = pos_q[AW-1:0];
        wdata = value_q;
      end
      default: we = 1'b0;
    endcase
  end

  suls_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // limit above depth saturates through the depth compare
  assign status_o.is_insert = (op_q == OP_INSERT);
  assign status_o.full      = (LW'(count_q) >= LW'(limit_q)) || (count_q == CW'(DEPTH));
  assign status_o.empty     = (count_q == '0);
  assign status_o.hit       = (rdata == value_q);
  assign status_o.above     = (rdata > value_q);
  assign status_o.last      = (idx_nx == count_q);
  assign status_o.at_pos    = (idx_q == pos_q);
  assign status_o.del_tail  = (idx_nx2 == count_q);

  assign out_data_o = out_q;

endmodule

[rtl/core/suls_ctrl.sv]
// suls_ctrl: sequencer for search, shift and result hand-off
// depends on suls_pkg

module suls_ctrl
  import suls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHECK    = 10'b00_0000_0010,
    S_SRCH_RD  = 10'b00_0000_0100,
    S_SRCH_CMP = 10'b00_0000_1000,
    S_INS_RD   = 10'b00_0001_0000,
    S_INS_WR   = 10'b00_0010_0000,
    S_INS_PUT  = 10'b00_0100_0000,
    S_DEL_RD   = 10'b00_1000_0000,
    S_DEL_WR   = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  always_comb begin
    state_d      = state_q;
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.wr_mode  = WR_NONE;
    cmd.st_code  = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          cmd.idx_op  = IDX_CLR;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.is_insert && status_i.full) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_FULL;
          state_d     = S_RESP;
        end else if (!status_i.is_insert && status_i.empty) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_MISS;
          state_d     = S_RESP;
        end else if (status_i.empty) begin
          // insert into an empty list goes straight to slot zero
          cmd.pos_save = 1'b1;
          state_d      = S_INS_PUT;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (status_i.is_insert) begin
          if (status_i.hit) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_DUP;
            state_d     = S_RESP;
          end else if (status_i.above) begin
            cmd.pos_save = 1'b1;
            cmd.idx_op   = IDX_TOP;
            state_d      = S_INS_RD;
          end else if (status_i.last) begin
            cmd.pos_save = 1'b1;
            cmd.pos_next = 1'b1;
            state_d      = S_INS_PUT;
          end else begin
            cmd.idx_op = IDX_INC;
            state_d    = S_SRCH_RD;
          end
        end else begin
          if (status_i.hit && status_i.last) begin
            cmd.cnt_dec = 1'b1;
            cmd.st_load = 1'b1;
            cmd.st_code = ST_DONE;
            state_d     = S_RESP;
          end else if (status_i.hit) begin
            state_d = S_DEL_RD;
          end else if (status_i.last) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_MISS;
            state_d     = S_RESP;
          end else begin
            cmd.idx_op = IDX_INC;
            state_d    = S_SRCH_RD;
          end
        end
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_mode = WR_UP;
        if (status_i.at_pos) begin
          state_d = S_INS_PUT;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_d    = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cmd.wr_mode = WR_PUT;
        cmd.cnt_inc = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st_code = ST_DONE;
        state_d     = S_RESP;
      end
      S_DEL_RD: begin
        cmd.rd_next = 1'b1;
        state_d     = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.wr_mode = WR_DOWN;
        if (status_i.del_tail) begin
          cmd.cnt_dec = 1'b1;
          cmd.st_load = 1'b1;
          cmd.st_code = ST_DONE;
          state_d     = S_RESP;
        end else begin
          cmd.idx_op = IDX_INC;
          state_d    = S_DEL_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[rtl/core/sorted_unique_list_store.sv]
// sorted_unique_list_store: top level joining the sequencer and the datapath
// depends on suls_pkg, suls_ctrl, suls_datapath (and through it suls_ram)

// Keeps an ascending list of distinct signed 32-bit values in a ram of DEPTH
// entries. An insert transaction puts the value at its sorted place, moving
// larger entries up; it is refused with list full when the count has reached
// the capacity limit (saturated at DEPTH) and with duplicate when the value is
// already held. A delete transaction removes the matching entry, moving later
// entries down, or reports not found (also on an empty list). Every input
// transaction gives one result carrying the status and the count afterwards.
// One transaction is worked at a time, and each entry visit takes a read state
// and then a compare or write state, because the single ram read port has a
// registered output. A full refusal or a delete on an empty list goes straight
// to the result; a duplicate ends the search where it is found, and a delete
// walks the list until it hits or reaches the end. A result waits while an
// earlier result is still stalled. The next transaction is accepted once the
// result sits in the output register, even if it is not yet taken.
// The entry ram has no reset and needs no clearing pass: only slots below the
// count are ever read. The capacity limit resets to 16 and is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle,
// as the block itself does not enforce this.

module sorted_unique_list_store
  import suls_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // result transactions
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // capacity limit register
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // sequencer: search pass, then a shift pass where needed, then the result hand-off
  suls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // entry ram, count, limit and the registered result
  suls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/suls_checker.sv]
// suls_checker: port-level assertions for the sorted unique list store, with its bind
// depends on suls_pkg and sorted_unique_list_store

module suls_checker
  import suls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  in_item_t            in_data_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // an accepted transaction leaves the block busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transaction");

  // a new result only appears out of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in progress");

  // the limit is only written with the block idle and with known data
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !$isunknown(cfg_wdata_i))
    else $error("limit written while busy or with unknown data");

endmodule

bind sorted_unique_list_store suls_checker u_suls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);
